>>> hdl/sha_pkg.sv
package sha_pkg;

    localparam int WordW   = 32;
    localparam int CountW  = 61;
    localparam int Rounds  = 64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_LEN,
        ST_EMIT
    } t_state;

    // command bundle from controller to datapath
    typedef struct packed {
        logic       take_byte;
        logic       start_blk;
        logic       do_round;
        logic       fold;
        logic       pad;
        logic       clear_blk;
        logic       put_len;
        logic       restart;
    } t_cmd;

    typedef struct packed {
        logic       blk_full;
        logic       pad_two;
    } t_status;

    function automatic logic [WordW-1:0] init_h(input logic [2:0] i);
        case (i)
            3'd0: init_h = 32'h6a09e667;
            3'd1: init_h = 32'hbb67ae85;
            3'd2: init_h = 32'h3c6ef372;
            3'd3: init_h = 32'ha54ff53a;
            3'd4: init_h = 32'h510e527f;
            3'd5: init_h = 32'h9b05688c;
            3'd6: init_h = 32'h1f83d9ab;
            default: init_h = 32'h5be0cd19;
        endcase
    endfunction

    function automatic logic [WordW-1:0] round_k(input logic [5:0] i);
        logic [WordW-1:0] k [0:63];
        k = '{
            32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
            32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
            32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
            32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
            32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
            32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
            32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
            32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
            32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
            32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
            32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
        round_k = k[i];
    endfunction

endpackage

>>> hdl/sha_if.sv
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
    modport source  (output valid, data_byte, has_byte, end_of_message, input ready);
    modport sink    (input valid, data_byte, has_byte, end_of_message, output ready);
    modport monitor (input valid, ready, data_byte, has_byte, end_of_message);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        final_word;
    modport source  (output valid, digest_word, word_index, final_word, input ready);
    modport sink    (input valid, digest_word, word_index, final_word, output ready);
    modport monitor (input valid, ready, digest_word, word_index, final_word);
endinterface

>>> hdl/sha_dp.sv
module sha_dp
    import sha_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  logic [7:0]       i_byte,
    input  logic [5:0]       i_round,
    input  logic [2:0]       i_widx,
    output t_status          o_status,
    output logic [WordW-1:0] o_word
);

    logic [WordW-1:0] r_w [0:15];
    logic [WordW-1:0] r_h [0:7];
    logic [WordW-1:0] r_v [0:7];
    logic [CountW-1:0] r_cnt;
    logic [WordW-1:0] n_w15, n_t1, n_t2, s0, s1, big0, big1, ch, mj, pw;
    logic [7:0] pb;
    logic [3:0] wsel;
    logic [1:0] bsel;

    assign wsel = r_cnt[5:2];
    assign bsel = r_cnt[1:0];
    assign o_status.blk_full = (r_cnt[5:0] == 6'd63);
    assign o_status.pad_two  = (r_cnt[5:0] >= 6'd56);
    assign o_word = r_h[i_widx];
    // the pad writes the 0x80 marker byte in place of a message byte
    assign pb = i_cmd.pad ? 8'h80 : i_byte;

    // rolling schedule: r_w[0] is the word of the current round
    always_comb begin
        s0 = {r_w[1][6:0], r_w[1][31:7]} ^ {r_w[1][17:0], r_w[1][31:18]} ^ (r_w[1] >> 3);
        s1 = {r_w[14][16:0], r_w[14][31:17]} ^ {r_w[14][18:0], r_w[14][31:19]}
             ^ (r_w[14] >> 10);
        n_w15 = r_w[0] + s0 + r_w[9] + s1;
        big1 = {r_v[4][5:0], r_v[4][31:6]} ^ {r_v[4][10:0], r_v[4][31:11]}
               ^ {r_v[4][24:0], r_v[4][31:25]};
        ch = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        big0 = {r_v[0][1:0], r_v[0][31:2]} ^ {r_v[0][12:0], r_v[0][31:13]}
               ^ {r_v[0][21:0], r_v[0][31:22]};
        mj = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        n_t1 = r_v[7] + big1 + ch + round_k(i_round) + r_w[0];
        n_t2 = big0 + mj;
        case (bsel)
            2'd0: pw = {pb, 24'h0};
            2'd1: pw = {r_w[wsel][31:24], pb, 16'h0};
            2'd2: pw = {r_w[wsel][31:16], pb, 8'h0};
            default: pw = {r_w[wsel][31:8], pb};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            for (int i = 0; i < 8; i++) r_h[i] <= init_h(3'(i));
        end else begin
            if (i_cmd.take_byte) begin
                r_w[wsel] <= pw;
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.pad) begin
                r_w[wsel] <= pw;
                for (int i = 0; i < 16; i++)
                    if (4'(i) > wsel && !(i_cmd.put_len && i >= 14)) r_w[i] <= '0;
            end
            // words 14 and 15 take the length from put_len
            if (i_cmd.clear_blk)
                for (int i = 0; i < 14; i++) r_w[i] <= '0;
            if (i_cmd.put_len) begin
                r_w[14] <= r_cnt[CountW-1:29];
                r_w[15] <= {r_cnt[28:0], 3'b000};
            end
            if (i_cmd.start_blk)
                for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
            if (i_cmd.do_round) begin
                for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
                r_w[15] <= n_w15;
                r_v[7] <= r_v[6];
                r_v[6] <= r_v[5];
                r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + n_t1;
                r_v[3] <= r_v[2];
                r_v[2] <= r_v[1];
                r_v[1] <= r_v[0];
                r_v[0] <= n_t1 + n_t2;
            end
            if (i_cmd.fold)
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
            if (i_cmd.restart) begin
                r_cnt <= '0;
                for (int i = 0; i < 8; i++) r_h[i] <= init_h(3'(i));
            end
        end
    end

endmodule

>>> hdl/sha_ctrl.sv
module sha_ctrl
    import sha_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_has_byte,
    input  logic    i_eom,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output logic [2:0] o_widx,
    output logic [5:0] o_round,
    input  logic    i_len_next,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic [5:0] r_round, n_round;
    logic [2:0] r_widx, n_widx;
    logic r_last, n_last;   // padding pending after this block
    logic r_lenblk, n_lenblk; // block in flight is the length block

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_round <= '0;
            r_widx <= '0;
            r_last <= 1'b0;
            r_lenblk <= 1'b0;
        end else begin
            r_state <= n_state;
            r_round <= n_round;
            r_widx <= n_widx;
            r_last <= n_last;
            r_lenblk <= n_lenblk;
        end
    end

    assign o_round = r_round;
    assign o_widx = r_widx;

    always_comb begin
        n_state = r_state;
        n_round = r_round;
        n_widx = r_widx;
        n_last = r_last;
        n_lenblk = r_lenblk;
        o_cmd = '0;
        o_in_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take_byte = i_has_byte;
                    n_last = i_eom;
                    n_lenblk = 1'b0;
                    if (i_has_byte && i_status.blk_full) begin
                        o_cmd.start_blk = 1'b1;
                        n_round = '0;
                        n_state = ST_ROUND;
                    end else if (i_eom) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_ROUND: begin
                o_cmd.do_round = 1'b1;
                n_round = r_round + 1'b1;
                if (r_round == 6'(Rounds - 1)) n_state = ST_FOLD;
            end
            ST_FOLD: begin
                o_cmd.fold = 1'b1;
                n_widx = '0;
                if (r_lenblk) n_state = ST_EMIT;
                else if (i_len_next) n_state = ST_LEN;
                else if (r_last) n_state = ST_PAD;
                else n_state = ST_IDLE;
            end
            ST_PAD: begin
                // append pad; length goes here unless it spills to a second block
                o_cmd.pad = 1'b1;
                o_cmd.start_blk = 1'b1;
                n_round = '0;
                n_state = ST_ROUND;
                if (i_status.pad_two) begin
                    n_last = 1'b0;
                    n_lenblk = 1'b0;
                end else begin
                    o_cmd.put_len = 1'b1;
                    n_lenblk = 1'b1;
                end
            end
            ST_LEN: begin
                // second block of a two-block pad: zeros plus length
                o_cmd.clear_blk = 1'b1;
                o_cmd.put_len = 1'b1;
                o_cmd.start_blk = 1'b1;
                n_round = '0;
                n_lenblk = 1'b1;
                n_state = ST_ROUND;
            end
            ST_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    n_widx = r_widx + 1'b1;
                    if (r_widx == 3'd7) begin
                        o_cmd.restart = 1'b1;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

>>> hdl/sha_lenq.sv
module sha_lenq
    import sha_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  logic    i_pad_two,
    input  logic    i_fold,
    output logic    o_len_next
);
    // remember that a zero block carrying the length must follow the next fold
    logic r_pend;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pend <= 1'b0;
        else if (i_cmd.pad && i_pad_two) r_pend <= 1'b1;
        else if (i_fold) r_pend <= 1'b0;
    end
    assign o_len_next = r_pend;
endmodule

>>> hdl/sha256_stream_hash_unit.sv
// SHA-256 over a byte stream. An input transaction is taken while the unit is idle.
// The 64th byte of each block starts a compression that holds input off through
// its 64 rounds on one shared round unit and then through one fold. The last
// transaction adds a pad step and a compression, plus a length step and a second
// compression when the pad byte lands at block position 56 or later; the eight
// digest words then leave one per accepted output transaction, word 0 first, and
// input stays held off until word 7 is taken.
module sha256_stream_hash_unit
    import sha_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    sha_in_if.sink    in_ch,
    sha_out_if.source out_ch
);

    t_cmd    cmd;
    t_status st;
    logic [5:0] round;
    logic [2:0] widx;
    logic len_next, out_valid;

    sha_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_ch.valid), .i_has_byte(in_ch.has_byte), .i_eom(in_ch.end_of_message),
        .o_in_ready(in_ch.ready), .i_out_ready(out_ch.ready), .o_out_valid(out_valid),
        .o_widx(widx), .o_round(round), .i_len_next(len_next), .i_status(st), .o_cmd(cmd)
    );

    sha_lenq u_lenq (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_pad_two(st.pad_two),
        .i_fold(cmd.fold), .o_len_next(len_next)
    );

    sha_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd),
        .i_byte(in_ch.data_byte), .i_round(round), .i_widx(widx), .o_status(st),
        .o_word(out_ch.digest_word)
    );

    assign out_ch.valid = out_valid;
    assign out_ch.word_index = widx;
    assign out_ch.final_word = (widx == 3'd7);

endmodule

>>> hdl/sha_chk.sv
module sha_chk (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic [2:0] word_index,
    input logic final_word
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("input open during digest");
    a_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_valid && in_ready) |=> !out_valid) else $error("digest right after input");
    a_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (final_word == (word_index == 3'd7))) else $error("final flag");
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && out_ready && !final_word) |=> (out_valid &&
        word_index == $past(word_index) + 3'd1)) else $error("word order");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_valid && !out_ready) |=> $stable(word_index)) else $error("index moved");
endmodule

bind sha256_stream_hash_unit sha_chk u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .word_index(out_ch.word_index), .final_word(out_ch.final_word)
);

>>> bench/sha256_digest_checker.sv
module sha256_digest_checker
    import sha_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    sha_in_if.monitor  in_mon,
    sha_out_if.monitor out_mon,
    output int      o_fail_count,
    output int      o_words_pending,
    output int      o_digest_count
);

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        final_word;
    } t_digest_word;

    logic [31:0]      msg_words [16];
    logic [31:0]      hash_h [8];
    logic [CountW-1:0] byte_count;
    t_digest_word     digest_q [$];

    function automatic logic [31:0] rotr(logic [31:0] v, int n);
        return (v >> n) | (v << (32 - n));
    endfunction

    function automatic logic [31:0] iv_word(int i);
        logic [31:0] iv [8];
        iv = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
               32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        return iv[i];
    endfunction

    task automatic compress();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] s0, s1, t1, t2;
        for (int i = 0; i < 16; i++) w[i] = msg_words[i];
        for (int i = 16; i < 64; i++) begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        for (int i = 0; i < 8; i++) v[i] = hash_h[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(i[5:0]) + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_h[i] += v[i];
    endtask

    task automatic put_byte(int pos, logic [7:0] b);
        int k;
        k = pos % 4;
        msg_words[pos / 4][31 - 8*k -: 8] = b;
        for (int j = k + 1; j < 4; j++) msg_words[pos / 4][31 - 8*j -: 8] = 8'h00;
    endtask

    task automatic absorb(logic [7:0] b, logic has, logic last);
        int pos;
        logic [63:0] bit_len;
        t_digest_word e;
        if (has) begin
            pos = int'(byte_count[5:0]);
            put_byte(pos, b);
            byte_count = byte_count + 1'b1;
            if (pos == 63) compress();
        end
        if (!last) return;
        pos = int'(byte_count[5:0]);
        put_byte(pos, 8'h80);
        for (int i = pos / 4 + 1; i < 16; i++) msg_words[i] = '0;
        if (pos >= 56) begin
            compress();
            for (int i = 0; i < 16; i++) msg_words[i] = '0;
        end
        bit_len = {byte_count, 3'b000};
        msg_words[14] = bit_len[63:32];
        msg_words[15] = bit_len[31:0];
        compress();
        for (int i = 0; i < 8; i++) begin
            e.digest_word = hash_h[i];
            e.word_index  = 3'(i);
            e.final_word  = (i == 7);
            digest_q.insert(digest_q.size(), e);
            hash_h[i] = iv_word(i);
        end
        byte_count = '0;
    endtask

    always @(posedge i_clk) begin
        t_digest_word e;
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) hash_h[i] = iv_word(i);
            for (int i = 0; i < 16; i++) msg_words[i] = '0;
            byte_count = '0;
            digest_q.delete();
            o_fail_count <= 0;
            o_digest_count <= 0;
        end else begin
            if (out_mon.valid && out_mon.ready) begin
                if (digest_q.size() == 0) begin
                    $error("digest word with nothing expected: %h", out_mon.digest_word);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    e = digest_q.pop_front();
                    if (out_mon.digest_word !== e.digest_word ||
                        out_mon.word_index !== e.word_index ||
                        out_mon.final_word !== e.final_word) begin
                        o_fail_count <= o_fail_count + 1;
                        if (out_mon.digest_word !== e.digest_word)
                            $error("digest_word: expected %h, got %h",
                                   e.digest_word, out_mon.digest_word);
                        if (out_mon.word_index !== e.word_index)
                            $error("word_index: expected %0d, got %0d",
                                   e.word_index, out_mon.word_index);
                        if (out_mon.final_word !== e.final_word)
                            $error("final_word: expected %0b, got %0b",
                                   e.final_word, out_mon.final_word);
                    end
                    if (e.final_word) o_digest_count <= o_digest_count + 1;
                end
            end
            if (in_mon.valid && in_mon.ready)
                absorb(in_mon.data_byte, in_mon.has_byte, in_mon.end_of_message);
        end
        o_words_pending <= digest_q.size();
    end

endmodule

>>> bench/tb_sha256_stream_hash_unit.sv
module tb_sha256_stream_hash_unit;

    localparam int StallLimit = 4000;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   words_pending;
    int   digest_count;
    int   idle_cycles;
    int   item_count;
    bit   calm_window;

    sha_in_if  in_ch ();
    sha_out_if out_ch ();

    sha256_stream_hash_unit DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    sha256_digest_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .in_mon         (in_ch.monitor),
        .out_mon        (out_ch.monitor),
        .o_fail_count   (fail_count),
        .o_words_pending(words_pending),
        .o_digest_count (digest_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic bit take_gap();
        return !calm_window && ($urandom_range(99) < 32);
    endfunction

    // sink side: random back-pressure
    always @(negedge i_clk) begin
        out_ch.ready <= i_rst_n && !take_gap();
    end

    // watchdog on cycles with no transaction
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > StallLimit) begin
            $display("watchdog expired with %0d words outstanding", words_pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // valid stays up after the transaction; the next item or a gap drops or reuses it
    task automatic send_item(logic [7:0] b, logic has, logic last);
        while (take_gap()) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.data_byte      <= b;
        in_ch.has_byte       <= has;
        in_ch.end_of_message <= last;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        item_count++;
        @(negedge i_clk);
    endtask

    task automatic send_message(int len, bit empty_end);
        for (int i = 0; i < len; i++)
            send_item(8'($urandom), 1'b1, !empty_end && (i == len - 1));
        if (empty_end || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    initial begin
        in_ch.valid          = 1'b0;
        in_ch.data_byte      = '0;
        in_ch.has_byte       = 1'b0;
        in_ch.end_of_message = 1'b0;
        out_ch.ready         = 1'b0;
        calm_window = 1'b0;
        item_count  = 0;
        i_rst_n     = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: empty message, byte extremes, idle items
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h5a, 1'b0, 1'b0);
        send_item(8'ha5, 1'b1, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);

        // block-length edges: one pad block vs. two, full block then empty end
        send_message(55, 1'b0);
        send_message(56, 1'b0);
        calm_window = 1'b1;
        send_message(64, 1'b1);
        calm_window = 1'b0;

        while (item_count < 220) begin
            case ($urandom_range(9))
                0:       send_item(8'($urandom), 1'b0, 1'b0);
                1:       send_item(8'($urandom), 1'b0, 1'b1);
                2:       send_message($urandom_range(54, 66), $urandom_range(1));
                default: send_message($urandom_range(0, 12), $urandom_range(1));
            endcase
        end
        in_ch.valid <= 1'b0;

        while (words_pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
        $display("sent %0d input transactions, checked %0d digests",
                 item_count, digest_count);
        if (fail_count == 0 && words_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
hdl/sha_pkg.sv
hdl/sha_if.sv
hdl/sha_dp.sv
hdl/sha_ctrl.sv
hdl/sha_lenq.sv
hdl/sha256_stream_hash_unit.sv
hdl/sha_chk.sv
bench/sha256_digest_checker.sv
bench/tb_sha256_stream_hash_unit.sv
